// ----- rtl/core/spl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted price level table package
// Word formats, command and status codes, and the cell control word shared
// by the table cells and the top level.
// ----------------------------------------------------------------------------
package spl_pkg;

  // Command codes of an input word.
  localparam logic [1:0] CMD_FIND   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_ERASE  = 2'd2;

  // Status codes of a result word.
  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_ERASED    = 3'd4;
  localparam logic [2:0] ST_DEFERRED  = 3'd5;
  localparam logic [2:0] ST_BAD_POS   = 3'd6;

  typedef struct packed {
    logic [1:0]         cmd;
    logic               side;
    logic signed [31:0] price;
    logic [7:0]         position;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         level_index;
    logic signed [31:0] best_bid;
    logic               bids_active;
    logic signed [31:0] best_ask;
    logic               asks_active;
  } out_word_t;

  // What every cell does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_INS,
    CELL_DEL
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     side;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/core/sorted_price_level_table_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted price level table core
// Bid and ask tables of distinct prices kept in ascending order in a row of
// compare-and-shift cells, with find, get-or-insert and erase commands.
// ----------------------------------------------------------------------------
// Sequence: an input word is accepted only in the idle state, and the input
// stalls until the result word is loaded in the done state. The cell row
// compares in the compare state and shifts in the decide state that follows;
// a successful erase that leaves entries adds the best-price read-out states.
// Reset clears counts, best prices, active flags, the erase deferral and the
// control state at once; table entries are not cleared and need no pass.
// ----------------------------------------------------------------------------
module sorted_price_level_table_core #(
  parameter int LEVELS     = 256,
  parameter int PRICE_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire spl_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output spl_pkg::out_word_t      out_word_o,
  input  wire logic               cfg_wr_en_i,
  input  wire logic               cfg_wr_data_i
);
  import spl_pkg::*;

  localparam int CNT_W = $clog2(LEVELS + 1);
  localparam int IDX_W = $clog2(LEVELS);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_DECIDE,
    S_PICK1,
    S_PICK2,
    S_DONE
  } state_e;

  state_e state_q;

  // Latched input word. The price is brought to PRICE_BITS by sign extension
  // or by dropping high bits.
  logic [1:0]                   cmd_q;
  logic                         side_q;
  logic signed [PRICE_BITS-1:0] price_q;
  logic [7:0]                   pos_q;
  logic [PRICE_BITS+31:0]       price_ext;

  // Per-side bookkeeping.
  logic [CNT_W-1:0]      cnt_q  [2];
  logic [PRICE_BITS-1:0] best_q [2];
  logic [1:0]            act_q;
  logic                  defer_q;

  // Result of the item in flight, and the output register.
  logic [2:0]       status_q, status_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_valid_q;
  out_word_t        out_word_q, out_word_d;

  // Cell row signals.
  cell_ctrl_t            cell_ctrl;
  logic [PRICE_BITS-1:0] val_w  [LEVELS];
  logic [PRICE_BITS-1:0] pick_w [LEVELS];
  logic [LEVELS-1:0]     lt_w, eq_w, e_vec;
  logic [PRICE_BITS-1:0] pick_data;

  logic [CNT_W-1:0] cnt_sel, cnt_m1;
  logic [CMP_W-1:0] pos_w, cnt_w;
  logic [IDX_W-1:0] tgt, p_idx;
  logic             found, full, pos_bad, ins_go, del_go;

  assign price_ext = {{PRICE_BITS{in_word_i.price[31]}}, in_word_i.price};

  assign cnt_sel = cnt_q[side_q];
  assign cnt_m1  = cnt_sel - CNT_W'(1);
  assign pos_w   = CMP_W'(pos_q);
  assign cnt_w   = CMP_W'(cnt_sel);
  assign full    = cnt_sel == CNT_W'(LEVELS);
  assign pos_bad = pos_w >= cnt_w;

  // Bids read back their highest entry (the last one), asks their lowest.
  assign tgt = side_q ? '0 : cnt_m1[IDX_W-1:0];

  // Entries below the price form a run from position 0, so the first cell
  // that is not below the price marks the sorted position. Past the count no
  // cell reports "below", so at most one edge exists.
  assign e_vec = ~lt_w & {lt_w[LEVELS-2:0], 1'b1};
  assign found = |eq_w;

  always_comb begin
    p_idx = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (e_vec[i]) begin
        p_idx = p_idx | IDX_W'(i);
      end
    end
  end

  // Command decode, valid while the compare flags are settled.
  always_comb begin
    status_d = ST_NOT_FOUND;
    idx_d    = '0;
    ins_go   = 1'b0;
    del_go   = 1'b0;
    case (cmd_q)
      CMD_FIND: begin
        if (found) begin
          status_d = ST_FOUND;
          idx_d    = p_idx;
        end
      end
      CMD_INSERT: begin
        if (found) begin
          status_d = ST_FOUND;
          idx_d    = p_idx;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_INSERTED;
          idx_d    = p_idx;
          ins_go   = 1'b1;
        end
      end
      CMD_ERASE: begin
        if (defer_q) begin
          status_d = ST_DEFERRED;
        end else if (pos_bad) begin
          status_d = ST_BAD_POS;
        end else begin
          status_d = ST_ERASED;
          del_go   = 1'b1;
        end
      end
      default: status_d = ST_NOT_FOUND;
    endcase
  end

  // The row compares during the compare state and shifts on the decide edge.
  always_comb begin
    cell_ctrl.side = side_q;
    case (state_q)
      S_CMP:    cell_ctrl.op = CELL_CMP;
      S_DECIDE: cell_ctrl.op = ins_go ? CELL_INS : (del_go ? CELL_DEL : CELL_HOLD);
      default:  cell_ctrl.op = CELL_HOLD;
    endcase
  end

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    logic [PRICE_BITS-1:0] left_v, right_v;
    logic                  lt_left;
    if (i == 0) begin : g_first
      assign left_v  = price_q;
      assign lt_left = 1'b1;
    end else begin : g_inner_l
      assign left_v  = val_w[i-1];
      assign lt_left = lt_w[i-1];
    end
    if (i == LEVELS - 1) begin : g_last
      assign right_v = val_w[i];
    end else begin : g_inner_r
      assign right_v = val_w[i+1];
    end

    spl_cell #(
      .PRICE_BITS (PRICE_BITS),
      .CNT_W      (CNT_W),
      .IDX_W      (IDX_W),
      .CMP_W      (CMP_W),
      .IDX        (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl),
      .price_i   (price_q),
      .cnt_i     (cnt_sel),
      .pos_i     (pos_w),
      .tgt_i     (tgt),
      .left_i    (left_v),
      .right_i   (right_v),
      .lt_left_i (lt_left),
      .val_o     (val_w[i]),
      .lt_o      (lt_w[i]),
      .eq_o      (eq_w[i]),
      .pick_o    (pick_w[i])
    );
  end

  spl_pick #(
    .LEVELS (LEVELS),
    .WIDTH  (PRICE_BITS)
  ) u_pick (
    .clk_i  (clk_i),
    .word_i (pick_w),
    .data_o (pick_data)
  );

  // Result word assembly from the state left after the item.
  logic [IDX_W+7:0]       idx_ext;
  logic [PRICE_BITS+31:0] bid_ext, ask_ext;

  assign idx_ext = {8'b0, idx_q};
  assign bid_ext = {{32{best_q[0][PRICE_BITS-1]}}, best_q[0]};
  assign ask_ext = {{32{best_q[1][PRICE_BITS-1]}}, best_q[1]};

  always_comb begin
    out_word_d.status      = status_q;
    out_word_d.level_index = idx_ext[7:0];
    out_word_d.best_bid    = bid_ext[31:0];
    out_word_d.bids_active = act_q[0];
    out_word_d.best_ask    = ask_ext[31:0];
    out_word_d.asks_active = act_q[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= CMD_FIND;
      side_q      <= 1'b0;
      price_q     <= '0;
      pos_q       <= '0;
      cnt_q[0]    <= '0;
      cnt_q[1]    <= '0;
      best_q[0]   <= '0;
      best_q[1]   <= '0;
      act_q       <= '0;
      defer_q     <= 1'b0;
      status_q    <= ST_NOT_FOUND;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        defer_q <= cfg_wr_data_i;
      end
      // In the done state the output register is either held or reloaded.
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q   <= in_word_i.cmd;
            side_q  <= in_word_i.side;
            price_q <= price_ext[PRICE_BITS-1:0];
            pos_q   <= in_word_i.position;
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          status_q <= status_d;
          idx_q    <= idx_d;
          if (ins_go) begin
            cnt_q[side_q] <= cnt_sel + CNT_W'(1);
          end
          if (del_go) begin
            cnt_q[side_q] <= cnt_m1;
            if (cnt_sel == CNT_W'(1)) begin
              best_q[side_q] <= '0;
              act_q[side_q]  <= 1'b0;
              state_q        <= S_DONE;
            end else begin
              state_q <= S_PICK1;
            end
          end else begin
            state_q <= S_DONE;
          end
        end
        S_PICK1: begin
          state_q <= S_PICK2;
        end
        S_PICK2: begin
          best_q[side_q] <= pick_data;
          act_q[side_q]  <= 1'b1;
          state_q        <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_word_q  <= out_word_d;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // A sorted table has at most one position where "below the price" ends.
  a_single_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DECIDE |-> $onehot0(e_vec))
    else $error("more than one sorted position found");

  // An exact match can only sit at the sorted position.
  a_found_at_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE && found) |-> eq_w[p_idx])
    else $error("match is not at the sorted position");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE && ins_go) |=>
      cnt_q[side_q] == $past(cnt_sel) + CNT_W'(1))
    else $error("insert did not grow the table by one");

  a_erase_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE && del_go) |=> cnt_q[side_q] == $past(cnt_m1))
    else $error("erase did not shrink the table by one");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] <= CNT_W'(LEVELS) && cnt_q[1] <= CNT_W'(LEVELS))
    else $error("table count beyond capacity");

endmodule
`default_nettype wire

// ----- rtl/core/spl_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Price level table cell
// Holds the bid and ask entry of one table position, compares the selected one
// with the broadcast price and shifts with its neighbors on insert and erase.
// ----------------------------------------------------------------------------
module spl_cell #(
  parameter int PRICE_BITS = 32,
  parameter int CNT_W      = 9,
  parameter int IDX_W      = 8,
  parameter int CMP_W      = 9,
  parameter int IDX        = 0
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire spl_pkg::cell_ctrl_t          ctrl_i,
  input  wire logic signed [PRICE_BITS-1:0] price_i,
  input  wire logic [CNT_W-1:0]             cnt_i,
  input  wire logic [CMP_W-1:0]             pos_i,
  input  wire logic [IDX_W-1:0]             tgt_i,
  input  wire logic [PRICE_BITS-1:0]        left_i,
  input  wire logic [PRICE_BITS-1:0]        right_i,
  input  wire logic                         lt_left_i,
  output logic [PRICE_BITS-1:0]             val_o,
  output logic                              lt_o,
  output logic                              eq_o,
  output logic [PRICE_BITS-1:0]             pick_o
);
  import spl_pkg::*;

  localparam logic [CNT_W-1:0] IDX_CNT = CNT_W'(IDX);
  localparam logic [CMP_W-1:0] IDX_CMP = CMP_W'(IDX);
  localparam logic [IDX_W-1:0] IDX_SEL = IDX_W'(IDX);

  logic [PRICE_BITS-1:0]        bid_q, bid_d;
  logic [PRICE_BITS-1:0]        ask_q, ask_d;
  logic signed [PRICE_BITS-1:0] cur;
  logic [PRICE_BITS-1:0]        nxt;
  logic                         in_use;
  logic                         lt_q, eq_q;

  assign cur    = ctrl_i.side ? ask_q : bid_q;
  assign in_use = IDX_CNT < cnt_i;

  always_comb begin
    case (ctrl_i.op)
      CELL_INS: nxt = lt_q ? cur : (lt_left_i ? price_i : left_i);
      CELL_DEL: nxt = (IDX_CMP >= pos_i) ? right_i : cur;
      default:  nxt = cur;
    endcase
    bid_d = ctrl_i.side ? bid_q : nxt;
    ask_d = ctrl_i.side ? nxt : ask_q;
  end

  always_ff @(posedge clk_i) begin
    bid_q <= bid_d;
    ask_q <= ask_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctrl_i.op == CELL_CMP) begin
      lt_q <= in_use && (cur < price_i);
      eq_q <= in_use && (cur == price_i);
    end
  end

  assign val_o  = cur;
  assign lt_o   = lt_q;
  assign eq_o   = eq_q;
  assign pick_o = (tgt_i == IDX_SEL) ? cur : '0;

endmodule
`default_nettype wire

// ----- rtl/core/spl_pick.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Table read-out tree
// Two-level OR reduction of the masked cell words; the group results are
// registered, so the selected entry appears in the cycle after it is offered.
// ----------------------------------------------------------------------------
module spl_pick #(
  parameter int LEVELS = 256,
  parameter int WIDTH  = 32
) (
  input  wire logic             clk_i,
  input  wire logic [WIDTH-1:0] word_i [LEVELS],
  output logic [WIDTH-1:0]      data_o
);

  localparam int GRP  = 16;
  localparam int NGRP = (LEVELS + GRP - 1) / GRP;

  logic [WIDTH-1:0] part_d [NGRP];
  logic [WIDTH-1:0] part_q [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      part_d[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < LEVELS) begin
          part_d[g] = part_d[g] | word_i[g * GRP + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
  end

  always_comb begin
    data_o = '0;
    for (int g = 0; g < NGRP; g++) begin
      data_o = data_o | part_q[g];
    end
  end

endmodule
`default_nettype wire

// ----- verif/tb_sorted_price_level_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the sorted price level table core
// Sends order book words (find, get-or-insert and erase on the bid and ask
// tables) through a directed table and a series of random phases. Each
// accepted word is run through a behavioral copy of the two sorted tables.
// Every result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sorted_price_level_table_core;
  import spl_pkg::*;

  localparam int LEVELS = 256;

  // The block treats the fourth command code as an unknown command.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Kinds of random traffic. Each phase of the run uses one kind.
  localparam int MODE_NARROW = 0;  // few distinct prices, many hits and erases
  localparam int MODE_WIDE   = 1;  // full 32-bit prices, mixed commands
  localparam int MODE_FILL   = 2;  // inserts on one side until the table is full
  localparam int MODE_DRAIN  = 3;  // erases on one side until the table is empty

  // Receiver stall patterns, switched at random intervals.
  localparam int STALL_NONE     = 0;
  localparam int STALL_LIGHT    = 1;
  localparam int STALL_PERIODIC = 2;
  localparam int STALL_HEAVY    = 3;

  typedef struct {
    logic [1:0]         cmd;
    bit                 side;
    logic signed [31:0] price;
    logic [7:0]         position;
    bit                 defer;
    bit                 typed;     // status and index below are the expectation
    logic [2:0]         status;
    logic [7:0]         level_index;
  } directed_row_t;

  typedef struct {
    int mode;
    bit side;
    bit defer;
    int items;
  } traffic_phase_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;
  logic      cfg_wr_en_i;
  logic      cfg_wr_data_i;

  sorted_price_level_table_core #(
    .LEVELS     (LEVELS),
    .PRICE_BITS (32)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_word_i     (in_word_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_word_o    (out_word_o),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i)
  );

  // Behavioral copy of the order book: both sorted tables, their counts,
  // the best prices, the active flags and the erase deferral bit.
  logic signed [31:0] book_levels [2][LEVELS];
  int unsigned        level_count [2];
  int unsigned        peak_count [2];
  logic signed [31:0] best_price [2];
  bit                 side_active [2];
  bit                 defer_erase_q;

  // Result words predicted for accepted input words, oldest first.
  out_word_t          pending_results [$];

  directed_row_t      directed_rows [$];
  traffic_phase_t     traffic_phases [$];

  int                 error_count;
  int                 words_sent;
  int                 results_checked;
  int                 status_seen [8];
  int                 cfg_writes;
  int                 burst_left;
  bit                 valid_held;
  int                 stall_mode;
  int                 stall_cycles_left;
  int                 stall_tick;
  out_word_t          oldest_result;

  // --------------------------------------------------------------------------
  // Clock, and a hard stop in case the block hangs.
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction. Applies one accepted word to the book copy and returns the
  // result word the block must give for it. The search is a plain linear
  // scan for the first entry not below the price, which is enough here.
  // --------------------------------------------------------------------------
  function automatic out_word_t book_step(input in_word_t w);
    out_word_t   r;
    int unsigned n;
    int unsigned p;
    int unsigned i;
    int          s;
    logic [2:0]  st;
    logic [7:0]  idx;
    s   = int'(w.side);
    n   = level_count[s];
    st  = ST_NOT_FOUND;
    idx = '0;
    if (w.cmd == CMD_FIND || w.cmd == CMD_INSERT) begin
      p = 0;
      while (p < n && $signed(book_levels[s][p]) < $signed(w.price)) p++;
      if (p < n && book_levels[s][p] == w.price) begin
        st  = ST_FOUND;
        idx = 8'(p);
      end else if (w.cmd == CMD_INSERT) begin
        if (n >= LEVELS) begin
          st = ST_FULL;
        end else begin
          for (i = n; i > p; i--) book_levels[s][i] = book_levels[s][i-1];
          book_levels[s][p] = w.price;
          level_count[s] = n + 1;
          if (n + 1 > peak_count[s]) peak_count[s] = n + 1;
          st  = ST_INSERTED;
          idx = 8'(p);
        end
      end
    end else if (w.cmd == CMD_ERASE) begin
      if (defer_erase_q) begin
        st = ST_DEFERRED;
      end else if (w.position >= n) begin
        st = ST_BAD_POS;
      end else begin
        for (i = w.position; i + 1 < n; i++) book_levels[s][i] = book_levels[s][i+1];
        n--;
        level_count[s] = n;
        // Only an erase moves the best price of its side: the highest bid or
        // the lowest ask, or zero and inactive once the side is empty.
        if (n == 0) begin
          side_active[s] = 1'b0;
          best_price[s]  = '0;
        end else begin
          side_active[s] = 1'b1;
          best_price[s]  = (s == 0) ? book_levels[s][n-1] : book_levels[s][0];
        end
        st = ST_ERASED;
      end
    end
    r.status      = st;
    r.level_index = idx;
    r.best_bid    = best_price[0];
    r.bids_active = side_active[0];
    r.best_ask    = best_price[1];
    r.asks_active = side_active[1];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random word generation. It reads the book copy so that erase positions
  // and find prices mostly land on real entries; the rest is noise.
  // --------------------------------------------------------------------------
  function automatic logic signed [31:0] some_price(input int s);
    if (level_count[s] > 0 && $urandom_range(3, 0) != 0)
      return book_levels[s][$urandom_range(level_count[s] - 1, 0)];
    return $urandom;
  endfunction

  function automatic in_word_t make_word(input int mode, input bit fixed_side);
    in_word_t    w;
    int unsigned n;
    int unsigned roll;
    w.cmd      = 2'($urandom_range(3, 0));
    w.side     = (mode == MODE_FILL || mode == MODE_DRAIN) ? fixed_side
                                                            : 1'($urandom_range(1, 0));
    w.price    = $urandom;
    w.position = 8'($urandom_range(255, 0));
    n          = level_count[w.side];
    roll       = $urandom_range(99, 0);
    case (mode)
      MODE_NARROW: begin
        w.price = 32'($urandom_range(31, 0)) - 32'd16;
        if (roll < 38) begin
          w.cmd = CMD_INSERT;
        end else if (roll < 70) begin
          w.cmd = CMD_ERASE;
          if (roll < 66 && n > 0) w.position = 8'($urandom_range(n - 1, 0));
        end else if (roll < 92) begin
          w.cmd = CMD_FIND;
        end
      end
      MODE_WIDE: begin
        if (roll < 40) begin
          w.cmd = CMD_INSERT;
          if (roll < 4) w.price = roll[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        end else if (roll < 60) begin
          w.cmd = CMD_ERASE;
          if (n > 0) w.position = 8'($urandom_range(n - 1, 0));
        end else if (roll < 80) begin
          w.cmd   = CMD_FIND;
          w.price = some_price(w.side);
        end
      end
      MODE_FILL: begin
        if (roll < 94) begin
          w.cmd = CMD_INSERT;
        end else begin
          w.cmd   = (roll < 97) ? CMD_FIND : CMD_INSERT;
          w.price = some_price(w.side);
        end
      end
      default: begin
        if (roll < 95) begin
          w.cmd = CMD_ERASE;
          if (n > 0) w.position = 8'($urandom_range(n - 1, 0));
        end else begin
          w.cmd   = CMD_FIND;
          w.price = some_price(w.side);
        end
      end
    endcase
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Sender. A word is held on the input until accepted, then predicted.
  // Words go out in bursts of random length with random gaps in between;
  // now and then a long burst runs with no gap at all.
  // --------------------------------------------------------------------------
  task automatic send_word(input in_word_t w, input bit typed,
                           input logic [2:0] st, input logic [7:0] idx);
    out_word_t predicted;
    in_word_i  <= w;
    in_valid_i <= 1'b1;
    valid_held  = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predicted = book_step(w);
    if (typed) begin
      predicted.status      = st;
      predicted.level_index = idx;
    end
    pending_results.push_back(predicted);
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      valid_held  = 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk_i);
      burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 20)
                                               : $urandom_range(6, 1);
    end
  endtask

  // Drops valid in the same time step as the last acceptance, so the word
  // that was just taken is never seen a second time.
  task automatic stop_sending();
    if (valid_held) begin
      in_valid_i <= 1'b0;
      valid_held  = 1'b0;
    end
  endtask

  // The deferral bit is only changed while the block is idle, that is once
  // every result is in.
  task automatic set_defer_erase(input bit value);
    if (value != defer_erase_q) begin
      stop_sending();
      while (pending_results.size() != 0) @(posedge clk_i);
      repeat (8) @(posedge clk_i);
      cfg_wr_en_i   <= 1'b1;
      cfg_wr_data_i <= value;
      @(posedge clk_i);
      cfg_wr_en_i   <= 1'b0;
      defer_erase_q  = value;
      cfg_writes++;
    end
  endtask

  function automatic directed_row_t mk_row(
    input logic [1:0] cmd, input bit side, input logic [31:0] price,
    input logic [7:0] position, input bit defer, input bit typed,
    input logic [2:0] st, input logic [7:0] idx);
    directed_row_t r;
    r.cmd         = cmd;
    r.side        = side;
    r.price       = price;
    r.position    = position;
    r.defer       = defer;
    r.typed       = typed;
    r.status      = st;
    r.level_index = idx;
    return r;
  endfunction

  function automatic traffic_phase_t mk_phase(input int mode, input bit side,
                                              input bit defer, input int items);
    traffic_phase_t ph;
    ph.mode  = mode;
    ph.side  = side;
    ph.defer = defer;
    ph.items = items;
    return ph;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver and checker. The stall pattern changes every so often between
  // no stalls, light random stalls, a fixed two-in-five pattern and heavy
  // random stalls. Each accepted result word is checked against the oldest
  // prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with no prediction waiting: status %0d", out_word_o.status);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        results_checked++;
        status_seen[oldest_result.status]++;
        if (out_word_o.status !== oldest_result.status) begin
          $error("status: expected %0d, actual %0d",
                 oldest_result.status, out_word_o.status);
          error_count++;
        end
        if (out_word_o.level_index !== oldest_result.level_index) begin
          $error("level_index: expected %0d, actual %0d",
                 oldest_result.level_index, out_word_o.level_index);
          error_count++;
        end
        if (out_word_o.best_bid !== oldest_result.best_bid) begin
          $error("best_bid: expected %0d, actual %0d",
                 oldest_result.best_bid, out_word_o.best_bid);
          error_count++;
        end
        if (out_word_o.bids_active !== oldest_result.bids_active) begin
          $error("bids_active: expected %0d, actual %0d",
                 oldest_result.bids_active, out_word_o.bids_active);
          error_count++;
        end
        if (out_word_o.best_ask !== oldest_result.best_ask) begin
          $error("best_ask: expected %0d, actual %0d",
                 oldest_result.best_ask, out_word_o.best_ask);
          error_count++;
        end
        if (out_word_o.asks_active !== oldest_result.asks_active) begin
          $error("asks_active: expected %0d, actual %0d",
                 oldest_result.asks_active, out_word_o.asks_active);
          error_count++;
        end
      end
    end

    if (stall_cycles_left <= 0) begin
      stall_mode        = $urandom_range(STALL_HEAVY, STALL_NONE);
      stall_cycles_left = $urandom_range(300, 60);
    end
    stall_cycles_left--;
    stall_tick = (stall_tick + 1) % 5;
    case (stall_mode)
      STALL_LIGHT:    out_stall_i <= ($urandom_range(2, 0) == 0);
      STALL_PERIODIC: out_stall_i <= (stall_tick < 2);
      STALL_HEAVY:    out_stall_i <= ($urandom_range(3, 0) != 0);
      default:        out_stall_i <= 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    in_word_i         = '0;
    out_stall_i       = 1'b0;
    cfg_wr_en_i       = 1'b0;
    cfg_wr_data_i     = 1'b0;
    defer_erase_q     = 1'b0;
    error_count       = 0;
    words_sent        = 0;
    results_checked   = 0;
    cfg_writes        = 0;
    burst_left        = 1;
    valid_held        = 1'b0;
    stall_mode        = STALL_NONE;
    stall_cycles_left = 40;
    stall_tick        = 0;
    foreach (status_seen[k]) status_seen[k] = 0;
    for (int s = 0; s < 2; s++) begin
      level_count[s] = 0;
      peak_count[s]  = 0;
      best_price[s]  = '0;
      side_active[s] = 1'b0;
    end

    // Directed rows. The comments say what each group of rows checks.
    // Empty book: find misses and erase at either end of the position range
    // is out of range.
    directed_rows.push_back(mk_row(CMD_FIND,  0, 32'd0,         8'd0,   0, 1, ST_NOT_FOUND, 0));
    directed_rows.push_back(mk_row(CMD_ERASE, 0, 32'd0,         8'd0,   0, 1, ST_BAD_POS,   0));
    directed_rows.push_back(mk_row(CMD_ERASE, 1, 32'hFFFF_FFFF, 8'd255, 0, 1, ST_BAD_POS,   0));
    // Bids: largest and smallest price, then zero in between.
    directed_rows.push_back(mk_row(CMD_INSERT, 0, 32'h7FFF_FFFF, 8'd0, 0, 1, ST_INSERTED, 0));
    directed_rows.push_back(mk_row(CMD_INSERT, 0, 32'h8000_0000, 8'd0, 0, 1, ST_INSERTED, 0));
    directed_rows.push_back(mk_row(CMD_INSERT, 0, 32'd0,         8'd0, 0, 1, ST_INSERTED, 1));
    directed_rows.push_back(mk_row(CMD_FIND,   0, 32'h7FFF_FFFF, 8'd0, 0, 1, ST_FOUND,    2));
    // Get-or-insert of a present price only reports its position.
    directed_rows.push_back(mk_row(CMD_INSERT, 0, 32'h8000_0000, 8'd9, 0, 1, ST_FOUND,    0));
    // Asks {-5, 100}. Inserting leaves both best prices untouched.
    directed_rows.push_back(mk_row(CMD_INSERT, 1, 32'd100,       8'd0, 0, 0, ST_INSERTED, 0));
    directed_rows.push_back(mk_row(CMD_INSERT, 1, -32'sd5,       8'd0, 0, 1, ST_INSERTED, 0));
    // The unused command code behaves as a miss and changes nothing.
    directed_rows.push_back(mk_row(CMD_UNUSED, 0, 32'd0,         8'd0, 0, 1, ST_NOT_FOUND, 0));
    directed_rows.push_back(mk_row(CMD_UNUSED, 1, 32'hA5A5_5A5A, 8'd255, 0, 1, ST_NOT_FOUND, 0));
    directed_rows.push_back(mk_row(CMD_FIND,   1, 32'd7,         8'd0, 0, 1, ST_NOT_FOUND, 0));
    // Erase the highest bid: best bid becomes zero and the side goes active.
    directed_rows.push_back(mk_row(CMD_ERASE,  0, 32'd0,         8'd2, 0, 1, ST_ERASED,   0));
    // Erase the lowest ask: best ask becomes 100.
    directed_rows.push_back(mk_row(CMD_ERASE,  1, 32'd0,         8'd0, 0, 1, ST_ERASED,   0));
    directed_rows.push_back(mk_row(CMD_ERASE,  1, 32'd0,         8'd1, 0, 1, ST_BAD_POS,  0));
    // Last ask erased: the ask side goes inactive with a zero best price.
    directed_rows.push_back(mk_row(CMD_ERASE,  1, 32'd0,         8'd0, 0, 1, ST_ERASED,   0));
    directed_rows.push_back(mk_row(CMD_ERASE,  0, 32'd0,         8'd255, 0, 1, ST_BAD_POS, 0));
    // Deferred erase reports deferral whatever the position and side.
    directed_rows.push_back(mk_row(CMD_ERASE,  0, 32'd0,         8'd0,   1, 1, ST_DEFERRED, 0));
    directed_rows.push_back(mk_row(CMD_ERASE,  1, 32'd0,         8'd255, 1, 1, ST_DEFERRED, 0));
    // Deferral off again: empty the bid side from the top down.
    directed_rows.push_back(mk_row(CMD_ERASE,  0, 32'd0,         8'd1, 0, 1, ST_ERASED,   0));
    directed_rows.push_back(mk_row(CMD_ERASE,  0, 32'd0,         8'd0, 0, 1, ST_ERASED,   0));
    directed_rows.push_back(mk_row(CMD_FIND,   0, 32'hFFFF_FFFF, 8'd0, 0, 1, ST_NOT_FOUND, 0));

    // Random phases: mixed traffic, deferred erases, each side filled to capacity
    // (so full tables are reached) and drained to empty, then wide mixed traffic.
    traffic_phases.push_back(mk_phase(MODE_NARROW, 0, 0, 250));
    traffic_phases.push_back(mk_phase(MODE_NARROW, 0, 1, 80));
    traffic_phases.push_back(mk_phase(MODE_FILL,   0, 0, 290));
    traffic_phases.push_back(mk_phase(MODE_DRAIN,  0, 0, 280));
    traffic_phases.push_back(mk_phase(MODE_FILL,   1, 0, 290));
    traffic_phases.push_back(mk_phase(MODE_DRAIN,  1, 0, 280));
    traffic_phases.push_back(mk_phase(MODE_WIDE,   0, 0, 250));
    traffic_phases.push_back(mk_phase(MODE_WIDE,   0, 1, 50));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    foreach (directed_rows[k]) begin
      set_defer_erase(directed_rows[k].defer);
      send_word('{cmd:      directed_rows[k].cmd,
                  side:     directed_rows[k].side,
                  price:    directed_rows[k].price,
                  position: directed_rows[k].position},
                directed_rows[k].typed, directed_rows[k].status,
                directed_rows[k].level_index);
    end

    foreach (traffic_phases[k]) begin
      set_defer_erase(traffic_phases[k].defer);
      repeat (traffic_phases[k].items)
        send_word(make_word(traffic_phases[k].mode, traffic_phases[k].side),
                  1'b0, ST_FOUND, 8'd0);
    end

    // Drain, then give the block time to show any stray result word.
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Checked %0d result words for %0d input words, %0d deferral writes.",
             results_checked, words_sent, cfg_writes);
    $display("Status mix: found %0d, inserted %0d, miss %0d, full %0d, erased %0d, deferred %0d, bad position %0d; peak levels bid %0d ask %0d.",
             status_seen[ST_FOUND], status_seen[ST_INSERTED], status_seen[ST_NOT_FOUND],
             status_seen[ST_FULL], status_seen[ST_ERASED], status_seen[ST_DEFERRED],
             status_seen[ST_BAD_POS], peak_count[0], peak_count[1]);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
